### hw/rtl/shell_sort_halving_gaps_top_assert.svh
// Assertion macros used by the port-level checker of the Shell sort block.
`ifndef SHELL_SORT_HALVING_GAPS_TOP_ASSERT_SVH
`define SHELL_SORT_HALVING_GAPS_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SHSORT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SHSORT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/shsort_pkg.sv
// Package with sizes and shared types of the Shell sort block.
`default_nettype none
package shsort_pkg;
	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef struct packed {
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [DATA_W-1:0] wr_data;
	} mem_req_t;
endpackage
`default_nettype wire

### hw/rtl/shsort_seq.sv
// Sort sequencer: gap-halving insertion passes over the element memory with one comparator.
`default_nettype none
module shsort_seq (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [shsort_pkg::CNT_W-1:0] count,
	input  wire logic [shsort_pkg::DATA_W-1:0] rd_data,
	output logic                              done,
	output shsort_pkg::mem_req_t              req
);
	localparam logic [2:0] SQ_IDLE     = 3'd0;
	localparam logic [2:0] SQ_RD_HELD  = 3'd1;
	localparam logic [2:0] SQ_GET_HELD = 3'd2;
	localparam logic [2:0] SQ_PROBE    = 3'd3;
	localparam logic [2:0] SQ_CMP      = 3'd4;
	localparam logic [2:0] SQ_FIN      = 3'd5;

	logic [2:0]                      state_q;
	logic [shsort_pkg::ADDR_W-1:0]   gap_q;
	logic [shsort_pkg::ADDR_W-1:0]   pos_q;
	logic [shsort_pkg::ADDR_W-1:0]   hole_q;
	logic [shsort_pkg::CNT_W-1:0]    cnt_q;
	logic [shsort_pkg::DATA_W-1:0]   held_q;

	logic                            greater;
	logic [shsort_pkg::CNT_W-1:0]    pos_inc;
	logic [shsort_pkg::ADDR_W-1:0]   gap_half;
	logic [shsort_pkg::ADDR_W-1:0]   first_gap;
	logic                            pass_end;

	assign greater   = $signed(rd_data) > $signed(held_q);
	assign pos_inc   = {1'b0, pos_q} + shsort_pkg::CNT_W'(1);
	assign gap_half  = gap_q >> 1;
	assign first_gap = count[shsort_pkg::CNT_W-1:1];
	assign pass_end  = (pos_inc == cnt_q);
	assign done      = (state_q == SQ_FIN);

	always_comb begin
		req.rd_addr = pos_q;
		req.wr_en   = 1'b0;
		req.wr_addr = hole_q;
		req.wr_data = held_q;
		unique case (state_q)
			SQ_PROBE: begin
				req.rd_addr = hole_q - gap_q;
				req.wr_en   = (hole_q < gap_q);
			end
			SQ_CMP: begin
				req.wr_en   = 1'b1;
				req.wr_data = greater ? rd_data : held_q;
			end
			default: begin
				req.rd_addr = pos_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			gap_q   <= '0;
			pos_q   <= '0;
			hole_q  <= '0;
			cnt_q   <= '0;
		end else begin
			unique case (state_q) inside
				SQ_IDLE: begin
					if (start) begin
						cnt_q   <= count;
						gap_q   <= first_gap;
						pos_q   <= first_gap;
						state_q <= (first_gap == '0) ? SQ_FIN : SQ_RD_HELD;
					end
				end
				SQ_RD_HELD: begin
					state_q <= SQ_GET_HELD;
				end
				SQ_GET_HELD: begin
					hole_q  <= pos_q;
					state_q <= SQ_PROBE;
				end
				SQ_PROBE, SQ_CMP: begin
					if (state_q == SQ_PROBE && hole_q >= gap_q) begin
						state_q <= SQ_CMP;
					end else if (state_q == SQ_CMP && greater) begin
						hole_q  <= hole_q - gap_q;
						state_q <= SQ_PROBE;
					end else if (!pass_end) begin
						pos_q   <= pos_inc[shsort_pkg::ADDR_W-1:0];
						state_q <= SQ_RD_HELD;
					end else if (gap_half == '0) begin
						state_q <= SQ_FIN;
					end else begin
						gap_q   <= gap_half;
						pos_q   <= gap_half;
						state_q <= SQ_RD_HELD;
					end
				end
				SQ_FIN: begin
					state_q <= SQ_IDLE;
				end
				default: begin
					state_q <= SQ_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SQ_GET_HELD) begin
			held_q <= rd_data;
		end
	end
endmodule
`default_nettype wire

### hw/rtl/shell_sort_halving_gaps_top.sv
// Top level of the Shell sort block: load, element memory, sort sequencer and result output.
//
//   channel  | role                 | tdata            | tlast     | tuser
//   s_axis   | elements in          | value            | last      | -
//   m_axis   | sorted elements out  | sorted_value     | final_res | overflowed
//
// Loading accepts one beat per cycle. After the last beat the input is held off while the
// sequencer sorts: each element visit of a gap pass reads the held element in SQ_RD_HELD
// and SQ_GET_HELD, then takes a probe and a compare step per compare, and one more probe
// when the element moves to the head of its chain, as the single read port of the element
// memory serves every access; SQ_FIN closes the sort. Each result beat passes ST_EMIT_RD,
// ST_EMIT_LD and ST_EMIT_WAIT, which waits out any stall on m_axis_tready. Reset clears the
// load count, the overflow flag and the sequencer control state; no clearing pass.
`default_nettype none
module shell_sort_halving_gaps_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] value
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // [31:0] sorted_value
	output logic             m_axis_tlast,
	output logic [0:0]       m_axis_tuser    // [0] overflowed
);
	localparam logic [2:0] ST_LOAD      = 3'd0;
	localparam logic [2:0] ST_SORT      = 3'd1;
	localparam logic [2:0] ST_EMIT_RD   = 3'd2;
	localparam logic [2:0] ST_EMIT_LD   = 3'd3;
	localparam logic [2:0] ST_EMIT_WAIT = 3'd4;

	logic [2:0]                      state_q;
	logic [shsort_pkg::CNT_W-1:0]    load_cnt_q;
	logic                            ovf_q;
	logic [shsort_pkg::ADDR_W-1:0]   k_q;
	logic                            out_valid_q;
	logic [shsort_pkg::DATA_W-1:0]   out_data_q;
	logic                            out_last_q;
	logic                            out_ovf_q;
	logic [shsort_pkg::DATA_W-1:0]   rd_data_q;
	logic [shsort_pkg::DATA_W-1:0]   mem [shsort_pkg::CAPACITY];

	logic                            in_acc;
	logic                            room;
	logic [shsort_pkg::CNT_W-1:0]    cnt_next;
	logic                            start;
	logic                            sort_done;
	shsort_pkg::mem_req_t            sort_req;
	logic                            wr_en;
	logic [shsort_pkg::ADDR_W-1:0]   wr_addr;
	logic [shsort_pkg::DATA_W-1:0]   wr_data;
	logic [shsort_pkg::ADDR_W-1:0]   rd_addr;

	assign s_axis_tready = (state_q == ST_LOAD);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign room          = (load_cnt_q != shsort_pkg::CNT_W'(shsort_pkg::CAPACITY));
	assign cnt_next      = load_cnt_q + {{(shsort_pkg::CNT_W-1){1'b0}}, room};
	assign start         = in_acc && s_axis_tlast;

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tuser  = out_ovf_q;

	shsort_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.count   (cnt_next),
		.rd_data (rd_data_q),
		.done    (sort_done),
		.req     (sort_req)
	);

	always_comb begin
		if (state_q == ST_SORT) begin
			wr_en   = sort_req.wr_en;
			wr_addr = sort_req.wr_addr;
			wr_data = sort_req.wr_data;
			rd_addr = sort_req.rd_addr;
		end else begin
			wr_en   = in_acc && room;
			wr_addr = load_cnt_q[shsort_pkg::ADDR_W-1:0];
			wr_data = s_axis_tdata;
			rd_addr = k_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			load_cnt_q  <= '0;
			ovf_q       <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						load_cnt_q <= cnt_next;
						ovf_q      <= ovf_q | !room;
						if (s_axis_tlast) begin
							k_q     <= '0;
							state_q <= ST_SORT;
						end
					end
				end
				ST_SORT: begin
					if (sort_done) begin
						state_q <= ST_EMIT_RD;
					end
				end
				ST_EMIT_RD: begin
					state_q <= ST_EMIT_LD;
				end
				ST_EMIT_LD: begin
					out_valid_q <= 1'b1;
					state_q     <= ST_EMIT_WAIT;
				end
				ST_EMIT_WAIT: begin
					if (m_axis_tready) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							load_cnt_q <= '0;
							ovf_q      <= 1'b0;
							state_q    <= ST_LOAD;
						end else begin
							k_q     <= k_q + shsort_pkg::ADDR_W'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_LD) begin
			out_data_q <= rd_data_q;
			out_last_q <= (({1'b0, k_q} + shsort_pkg::CNT_W'(1)) == load_cnt_q);
			out_ovf_q  <= ovf_q;
		end
	end
endmodule
`default_nettype wire

### hw/rtl/shsort_check.sv
// Port-level checker for the Shell sort block, bound to its top level.
`default_nettype none
`include "shell_sort_halving_gaps_top_assert.svh"
module shsort_check (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        s_axis_tlast,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic        m_axis_tlast,
	input wire logic [0:0]  m_axis_tuser
);
	// The block never takes a new element while a sorted result is on offer.
	`SHSORT_ASSERT_NOW(a_no_load_while_out, m_axis_tvalid, !s_axis_tready,
		"input ready during output")
	// The beat that ends a set stops the input for the sort.
	`SHSORT_ASSERT_NEXT(a_hold_after_last, s_axis_tvalid && s_axis_tready && s_axis_tlast,
		!s_axis_tready, "input ready right after last beat")
	// After the final result the output goes quiet.
	`SHSORT_ASSERT_NEXT(a_quiet_after_final, m_axis_tvalid && m_axis_tready && m_axis_tlast,
		!m_axis_tvalid, "output valid right after final beat")
	// A stalled result beat holds its payload.
	`SHSORT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
		$stable(m_axis_tuser), "stalled output beat changed")
endmodule

bind shell_sort_halving_gaps_top shsort_check u_check (.*);
`default_nettype wire

### sim/shell_sort_halving_gaps_checker.sv
// Checker for the Shell sort block: predicts each sorted set and compares the output beats.
module shell_sort_halving_gaps_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] value
	input  wire logic        s_axis_tlast,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [31:0] m_axis_tdata,   // [31:0] sorted_value
	input  wire logic        m_axis_tlast,
	input  wire logic [0:0]  m_axis_tuser,   // [0] overflowed
	input  wire logic        done,
	output int               errors,
	output int               outstanding,
	output int               checked
);
	typedef struct packed {
		logic [shsort_pkg::DATA_W-1:0] value;
		logic                          is_final;
		logic                          dropped;
	} sorted_beat_t;

	sorted_beat_t                         sorted_q[$];
	logic signed [shsort_pkg::DATA_W-1:0] held_set [shsort_pkg::CAPACITY];
	int unsigned                          held_count;
	bit                                   any_dropped;
	bit                                   done_seen;

	task automatic report(input string what);
		errors++;
		$display("MISMATCH at %0t: %s", $time, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		sorted_beat_t                         beat;
		logic signed [shsort_pkg::DATA_W-1:0] moving;
		int unsigned                          stride, head, pos, slot;
		if (!arst_n) begin
			held_count  = 0;
			any_dropped = 1'b0;
			done_seen   = 1'b0;
			sorted_q.delete();
			outstanding <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (held_count < shsort_pkg::CAPACITY) begin
					held_set[held_count] = s_axis_tdata;
					held_count++;
				end else begin
					any_dropped = 1'b1;
				end
				if (s_axis_tlast) begin
					// Gap sequence n/2, n/4, ... 1; each pass is an insertion sort per chain.
					stride = held_count / 2;
					while (stride >= 1) begin
						for (head = 0; head < stride; head++) begin
							for (pos = head + stride; pos < held_count; pos += stride) begin
								moving = held_set[pos];
								slot   = pos;
								while (slot >= head + stride && held_set[slot - stride] > moving) begin
									held_set[slot] = held_set[slot - stride];
									slot -= stride;
								end
								held_set[slot] = moving;
							end
						end
						stride /= 2;
					end
					for (pos = 0; pos < held_count; pos++) begin
						beat.value    = held_set[pos];
						beat.is_final = (pos + 1 == held_count);
						beat.dropped  = any_dropped;
						sorted_q.push_back(beat);
					end
					held_count  = 0;
					any_dropped = 1'b0;
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (sorted_q.size() == 0) begin
					report($sformatf("sorted beat %0d with nothing expected", $signed(m_axis_tdata)));
				end else begin
					beat = sorted_q.pop_front();
					checked++;
					if (m_axis_tdata !== beat.value)
						report($sformatf("sorted_value %0d, expected %0d",
							$signed(m_axis_tdata), $signed(beat.value)));
					if (m_axis_tlast !== beat.is_final)
						report($sformatf("final_res %b, expected %b", m_axis_tlast, beat.is_final));
					if (m_axis_tuser[0] !== beat.dropped)
						report($sformatf("overflowed %b, expected %b", m_axis_tuser[0], beat.dropped));
				end
			end
			if (done && !done_seen) begin
				done_seen = 1'b1;
				if (sorted_q.size() != 0)
					report($sformatf("%0d sorted beats never arrived", sorted_q.size()));
			end
			outstanding <= sorted_q.size();
		end
	end
endmodule

### sim/shell_sort_halving_gaps_top_test.sv
// Testbench top for the Shell sort block: stimulus, output backpressure and the verdict.
module shell_sort_halving_gaps_top_test;
	localparam int CYCLE_LIMIT    = 1_000_000;
	localparam int RANDOM_ITEMS   = 280;
	localparam int DIRECTED_ITEMS = 16;
	localparam int SETTLE_CYCLES  = 100;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata  = '0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [0:0]  m_axis_tuser;
	logic        done          = 1'b0;

	int in_gap_pct    = 0;
	int out_stall_pct = 0;
	int cycles        = 0;
	int elements_sent = 0;
	int sets_sent     = 0;
	int errors, outstanding, checked;

	logic [31:0] directed_vals [DIRECTED_ITEMS] = '{
		32'h8000_0000,
		32'h7fff_ffff, 32'h8000_0000,
		32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0000, 32'hffff_ffff,
		32'h7fff_ffff, 32'h0000_1000, 32'h0000_0001, 32'h0000_0000,
		32'hffff_ffff, 32'hffff_f000, 32'h8000_0001, 32'h8000_0000
	};
	bit directed_last [DIRECTED_ITEMS] = '{1, 0, 1, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 1};

	shell_sort_halving_gaps_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	shell_sort_halving_gaps_checker sort_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.done          (done),
		.errors        (errors),
		.outstanding   (outstanding),
		.checked       (checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles        <= cycles + 1;
		m_axis_tready <= ($urandom_range(99) >= out_stall_pct);
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic send_beat(input logic [31:0] value, input logic is_last);
		while ($urandom_range(99) < in_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= value;
		s_axis_tlast  <= is_last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		elements_sent++;
		if (is_last)
			sets_sent++;
	endtask

	task automatic send_set(input int size, input int kind);
		logic [31:0] value;
		for (int i = 0; i < size; i++) begin
			case (kind)
			0: value = $urandom;
			1: value = 32'($urandom_range(8)) - 32'd4;
			default: begin
				case ($urandom_range(3))
				0: value = 32'h8000_0000;
				1: value = 32'h7fff_ffff;
				2: value = 32'($urandom_range(1)) - 32'd1;
				default: value = $urandom;
				endcase
			end
			endcase
			send_beat(value, i == size - 1);
		end
	endtask

	initial begin
		int phase_start;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_ITEMS; i++)
			send_beat(directed_vals[i], directed_last[i]);

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
			0: begin
				in_gap_pct    = 0;
				out_stall_pct <= 0;
			end
			1: begin
				in_gap_pct    = 53;
				out_stall_pct <= 0;
			end
			2: begin
				in_gap_pct    = 0;
				out_stall_pct <= 53;
			end
			default: begin
				in_gap_pct    = 18;
				out_stall_pct <= 18;
			end
			endcase
			phase_start = elements_sent;
			// A full store, one drop on the last beat itself, and several drops.
			case (phase)
			1: send_set(shsort_pkg::CAPACITY, 0);
			2: send_set(shsort_pkg::CAPACITY + 1, 2);
			3: send_set(shsort_pkg::CAPACITY + $urandom_range(2, 10), 1);
			default: ;
			endcase
			while (elements_sent - phase_start < (RANDOM_ITEMS - DIRECTED_ITEMS) / 4) begin
				if ($urandom_range(99) < 15)
					send_set($urandom_range(13, 40), $urandom_range(2));
				else
					send_set($urandom_range(1, 12), $urandom_range(2));
			end
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		done <= 1'b1;
		repeat (2) @(posedge clk);

		$display("Loaded %0d elements in %0d sets, checked %0d sorted beats,", elements_sent,
			sets_sent, checked);
		$display("including full and overflowing sets, under four input and output stall mixes.");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/shsort_pkg.sv
hw/rtl/shsort_seq.sv
hw/rtl/shell_sort_halving_gaps_top.sv
hw/rtl/shsort_check.sv
sim/shell_sort_halving_gaps_checker.sv
sim/shell_sort_halving_gaps_top_test.sv
